>>> hw/rtl/sltrk_pkg.sv
// Shared types and constants for the sequence loss window tracker.
`timescale 1ns / 1ps
`default_nettype none

package sltrk_pkg;

    localparam int WINDOW_WORDS = 4;
    localparam int WORD_BITS    = 32;
    localparam int WINDOW_BITS  = WINDOW_WORDS * WORD_BITS;
    localparam int WORD_LG      = $clog2(WORD_BITS);
    localparam int IDX_W        = (WINDOW_WORDS > 1) ? $clog2(WINDOW_WORDS) : 1;

    localparam int SEQ_W   = 32;
    localparam int LEN_W   = 16;
    localparam int CNT_W   = 32;
    localparam int BYTES_W = 64;
    // ceil(diff / WORD_BITS) for a full-range 32-bit diff
    localparam int SHIFT_W = SEQ_W - WORD_LG + 1;
    localparam int ZCNT_W  = $clog2(WORD_BITS + 1);

    localparam int IN_DATA_W  = 48;   // seq_number + byte_length
    localparam int OUT_DATA_W = 168;  // 161 bits of fields, padded to bytes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [SEQ_W-1:0] FIRST_LIMIT_RST = 32'd10000;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LIMIT = 1'd1;

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_ADV,
        S_BULK,
        S_SHIFT,
        S_DIST,
        S_MARK,
        S_DONE
    } t_state;

    // number of unmarked bits in one window word
    function automatic logic [ZCNT_W-1:0] count_zeros(input t_word w);
        logic [ZCNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            n = n + ZCNT_W'(~w[i]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sequence_loss_window_tracker_unit.sv
// Sequence loss window tracker: seen-mark window, loss/duplicate/reorder counters.
//
//  channel  dir  handshake              payload (low bit up)
//  s_axis   in   tvalid/tready          tuser: cmd; tdata: seq_number, byte_length
//  m_axis   out  tvalid/tready          tdata: lost, duplicate, out_of_order,
//                                              received_bytes, tracking_disabled
//  cfg      in   i_cfg_we (no wait)     i_cfg_idx, i_cfg_data
//
// A read command or an ignored packet goes from S_START to S_DONE. A packet
// inside the window passes S_DIST and S_MARK, one above the top also S_ADV,
// S_BULK, S_SHIFT, shifting up to WINDOW_WORDS words out one per cycle through
// the shared zero counter. Reset is synchronous and clears the window to all
// marked. A result waits in the output register; the next word is accepted
// while it waits, and the sequencer holds in its last state until it drains.
`timescale 1ns / 1ps
`default_nettype none

module sequence_loss_window_tracker_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [sltrk_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // seq_number, byte_length
    input  wire                                 s_axis_tuser,  // cmd
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // lost_count, duplicate_count, out_of_order_count, received_bytes,
    // tracking_disabled, zero pad
    output logic [sltrk_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  wire                                 i_cfg_we,
    input  wire  [sltrk_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [sltrk_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import sltrk_pkg::*;

    t_state r_state, n_state;

    logic               r_enable;
    logic [SEQ_W-1:0]   r_first_limit;

    logic               r_cmd;
    logic [SEQ_W-1:0]   r_seq;
    logic [LEN_W-1:0]   r_len;

    logic               r_awaiting, n_awaiting;
    logic               r_disabled, n_disabled;
    logic [SEQ_W-1:0]   r_top, n_top;
    logic [SEQ_W-1:0]   r_latest, n_latest;
    t_word              r_seen [WINDOW_WORDS];
    t_word              n_seen [WINDOW_WORDS];
    logic [CNT_W-1:0]   r_lost, n_lost;
    logic [CNT_W-1:0]   r_dup, n_dup;
    logic [CNT_W-1:0]   r_reorder, n_reorder;
    logic [BYTES_W-1:0] r_bytes, n_bytes;

    logic [SEQ_W-1:0]   r_diff, n_diff;
    logic [SHIFT_W-1:0] r_shift, n_shift;
    logic [SEQ_W-1:0]   r_dist, n_dist;

    logic               r_out_valid, n_out_valid;
    logic [CNT_W-1:0]   r_out_lost, r_out_dup, r_out_reorder;
    logic [BYTES_W-1:0] r_out_bytes;
    logic               r_out_disabled;
    logic               w_load;

    logic [SEQ_W:0]     w_diff_ext;
    logic [IDX_W-1:0]   w_idx;
    logic [WORD_LG-1:0] w_bit;
    t_word              w_word;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_disabled, r_out_bytes, r_out_reorder,
                            r_out_dup, r_out_lost};

    assign w_diff_ext = {1'b0, r_seq} - {1'b0, r_top};
    assign w_idx      = IDX_W'(WINDOW_WORDS - 1) - r_dist[WORD_LG +: IDX_W];
    assign w_bit      = r_dist[WORD_LG-1:0];
    assign w_word     = r_seen[w_idx];
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b0;
            r_first_limit <= FIRST_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE:      r_enable      <= i_cfg_data[0];
                CFG_FIRST_LIMIT: r_first_limit <= i_cfg_data[SEQ_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_awaiting  <= 1'b1;
            r_disabled  <= 1'b0;
            r_top       <= '0;
            r_latest    <= '0;
            r_lost      <= '0;
            r_dup       <= '0;
            r_reorder   <= '0;
            r_bytes     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < WINDOW_WORDS; i++) begin
                r_seen[i] <= '1;
            end
        end else begin
            r_state     <= n_state;
            r_awaiting  <= n_awaiting;
            r_disabled  <= n_disabled;
            r_top       <= n_top;
            r_latest    <= n_latest;
            r_lost      <= n_lost;
            r_dup       <= n_dup;
            r_reorder   <= n_reorder;
            r_bytes     <= n_bytes;
            r_out_valid <= n_out_valid;
            r_seen      <= n_seen;
        end
    end

    // payload, working and output registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd <= s_axis_tuser;
            r_seq <= s_axis_tdata[SEQ_W-1:0];
            r_len <= s_axis_tdata[SEQ_W +: LEN_W];
        end
        r_diff  <= n_diff;
        r_shift <= n_shift;
        r_dist  <= n_dist;
        if (w_load) begin
            r_out_lost     <= r_lost;
            r_out_dup      <= r_dup;
            r_out_reorder  <= r_reorder;
            r_out_bytes    <= r_bytes;
            r_out_disabled <= r_disabled;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_awaiting  = r_awaiting;
        n_disabled  = r_disabled;
        n_top       = r_top;
        n_latest    = r_latest;
        n_seen      = r_seen;
        n_lost      = r_lost;
        n_dup       = r_dup;
        n_reorder   = r_reorder;
        n_bytes     = r_bytes;
        n_diff      = r_diff;
        n_shift     = r_shift;
        n_dist      = r_dist;
        n_out_valid = r_out_valid;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = S_DONE;
                if (r_cmd == CMD_PACKET && r_enable) begin
                    n_bytes = r_bytes + BYTES_W'(r_len);
                    if (r_awaiting) begin
                        n_awaiting = 1'b0;
                        n_disabled = (r_seq > r_first_limit);
                        n_top      = r_seq;
                    end else if (!r_disabled) begin
                        n_diff = w_diff_ext[SEQ_W-1:0];
                        if (!w_diff_ext[SEQ_W] && (w_diff_ext[SEQ_W-1:0] != '0)) begin
                            n_latest = r_seq;
                            n_state  = S_ADV;
                        end else begin
                            n_state  = S_DIST;
                        end
                    end
                end
            end
            S_ADV: begin
                // round the distance up to whole words
                n_shift = SHIFT_W'(r_diff >> WORD_LG)
                        + SHIFT_W'(r_diff[WORD_LG-1:0] != '0);
                n_state = S_BULK;
            end
            S_BULK: begin
                n_top = r_top + SEQ_W'({r_shift, {WORD_LG{1'b0}}});
                if (r_shift > SHIFT_W'(WINDOW_WORDS)) begin
                    // words jumped over entirely are all lost
                    n_lost  = r_lost + CNT_W'({r_shift - SHIFT_W'(WINDOW_WORDS),
                                               {WORD_LG{1'b0}}});
                    n_shift = SHIFT_W'(WINDOW_WORDS);
                end
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                // drop the oldest word, counting its holes
                n_lost = r_lost + CNT_W'(count_zeros(r_seen[0]));
                for (int i = 0; i < WINDOW_WORDS - 1; i++) begin
                    n_seen[i] = r_seen[i+1];
                end
                n_seen[WINDOW_WORDS-1] = '0;
                n_shift = r_shift - SHIFT_W'(1);
                if (r_shift == SHIFT_W'(1)) begin
                    n_state = S_DIST;
                end
            end
            S_DIST: begin
                n_dist  = r_top - r_seq;
                n_state = S_MARK;
            end
            S_MARK: begin
                if (r_dist < SEQ_W'(WINDOW_BITS)) begin
                    if (w_word[w_bit]) begin
                        n_dup = r_dup + CNT_W'(1);
                    end else begin
                        n_seen[w_idx][w_bit] = 1'b1;
                        if (r_seq < r_latest) begin
                            n_reorder = r_reorder + CNT_W'(1);
                        end
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    if (r_cmd == CMD_READ) begin
                        n_lost    = '0;
                        n_dup     = '0;
                        n_reorder = '0;
                        n_bytes   = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_shift != '0 && r_shift <= SHIFT_W'(WINDOW_WORDS)))
        else $error("window shift count out of range");

    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_cmd == CMD_READ)
        |=> (r_lost == '0 && r_dup == '0 && r_reorder == '0 && r_bytes == '0))
        else $error("counters not cleared after read");

    a_disable_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_disabled) |-> ($past(r_awaiting) && !r_awaiting))
        else $error("tracking disabled outside first packet");

    a_load_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not presented after load");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_START))
        else $error("accepted word not started");

endmodule

`default_nettype wire
